// File: hw/rtl/epdwcg_pkg.sv
`timescale 1ns / 1ps

package epdwcg_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CMD_XRANGE = 8'h44;
    localparam logic [7:0] CMD_YRANGE = 8'h45;
    localparam logic [7:0] CMD_XCOUNT = 8'h4E;
    localparam logic [7:0] CMD_YCOUNT = 8'h4F;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_GATE_LINES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PIX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_WIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_WIDE = 3'd4;

    localparam logic [1:0] ROT_0 = 2'd0;
    localparam logic [1:0] ROT_1 = 2'd1;
    localparam logic [1:0] ROT_2 = 2'd2;
    localparam logic [1:0] ROT_3 = 2'd3;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] SLOT_XR_CMD = 4'd0;
    localparam logic [STEP_W-1:0] SLOT_XR_SLO = 4'd1;
    localparam logic [STEP_W-1:0] SLOT_XR_SHI = 4'd2;
    localparam logic [STEP_W-1:0] SLOT_XR_ELO = 4'd3;
    localparam logic [STEP_W-1:0] SLOT_XR_EHI = 4'd4;
    localparam logic [STEP_W-1:0] SLOT_YR_CMD = 4'd5;
    localparam logic [STEP_W-1:0] SLOT_YR_SLO = 4'd6;
    localparam logic [STEP_W-1:0] SLOT_YR_SHI = 4'd7;
    localparam logic [STEP_W-1:0] SLOT_YR_ELO = 4'd8;
    localparam logic [STEP_W-1:0] SLOT_YR_EHI = 4'd9;
    localparam logic [STEP_W-1:0] SLOT_XC_CMD = 4'd10;
    localparam logic [STEP_W-1:0] SLOT_XC_LO = 4'd11;
    localparam logic [STEP_W-1:0] SLOT_XC_HI = 4'd12;
    localparam logic [STEP_W-1:0] SLOT_YC_CMD = 4'd13;
    localparam logic [STEP_W-1:0] SLOT_YC_LO = 4'd14;
    localparam logic [STEP_W-1:0] SLOT_YC_HI = 4'd15;

    typedef struct packed {
        logic [8:0] gate_lines;
        logic [4:0] source_bytes;
        logic [1:0] rotation;
        logic       x_wide;
        logic       y_wide;
    } t_cfg;

    typedef struct packed {
        logic       rejected;
        logic       x_wide;
        logic       y_wide;
        logic [4:0] xs;
        logic [4:0] xe;
        logic [8:0] ys;
        logic [8:0] ye;
    } t_job;

    typedef struct packed {
        logic       is_command;
        logic [7:0] byte_value;
        logic       last;
        logic       rejected;
    } t_beat;

    function automatic logic slot_on(input logic [STEP_W-1:0] slot, input logic xw,
                                     input logic yw);
        logic on;
        on = 1'b1;
        if (slot inside {SLOT_XR_SHI, SLOT_XR_EHI, SLOT_XC_HI}) begin
            on = xw;
        end else if (slot inside {SLOT_YR_SHI, SLOT_YR_EHI, SLOT_YC_HI}) begin
            on = yw;
        end
        return on;
    endfunction

endpackage

// File: hw/rtl/epdwcg_front.sv
`timescale 1ns / 1ps

module epdwcg_front (
    input  epdwcg_pkg::t_cfg i_cfg,
    input  logic             i_valid,
    input  logic [15:0]      i_win_x,
    input  logic [15:0]      i_win_y,
    input  logic [15:0]      i_win_w,
    input  logic [15:0]      i_win_h,
    input  logic             i_full,
    output logic             o_push,
    output epdwcg_pkg::t_job o_job
);
    import epdwcg_pkg::*;

    logic        odd_rot;
    logic [16:0] sa;
    logic [16:0] sl;
    logic [16:0] ga;
    logic [16:0] gn;
    logic [16:0] src_ext;
    logic [16:0] gate_ext;
    logic [16:0] g_end;
    logic [16:0] s_end;
    logic [16:0] xs_full;
    logic [16:0] xe_full;
    logic [16:0] ys_full;
    logic [16:0] ye_full;
    logic        bad;

    assign odd_rot  = i_cfg.rotation[0];
    assign sa       = {1'b0, odd_rot ? i_win_x : i_win_y};
    assign sl       = {1'b0, odd_rot ? i_win_w : i_win_h};
    assign ga       = {1'b0, odd_rot ? i_win_y : i_win_x};
    assign gn       = {1'b0, odd_rot ? i_win_h : i_win_w};
    assign src_ext  = {9'd0, i_cfg.source_bytes, 3'd0};
    assign gate_ext = {8'd0, i_cfg.gate_lines};
    assign g_end    = ga + gn;
    assign s_end    = sa + sl;

    assign bad = (i_win_w == 16'd0) || (i_win_h == 16'd0) || (g_end > gate_ext)
              || (s_end > src_ext) || (sa[2:0] != 3'd0) || (sl[2:0] != 3'd0);

    always_comb begin
        case (i_cfg.rotation)
            ROT_0: begin
                xs_full = src_ext - 17'd1 - sa;
                xe_full = src_ext - s_end;
                ys_full = ga;
                ye_full = g_end - 17'd1;
            end
            ROT_1: begin
                xs_full = src_ext - 17'd1 - sa;
                xe_full = src_ext - s_end;
                ys_full = gate_ext - 17'd1 - ga;
                ye_full = gate_ext - g_end;
            end
            ROT_2: begin
                xs_full = sa;
                xe_full = s_end - 17'd1;
                ys_full = g_end - 17'd1;
                ye_full = ga;
            end
            default: begin
                xs_full = sa;
                xe_full = s_end - 17'd1;
                ys_full = ga;
                ye_full = g_end - 17'd1;
            end
        endcase
    end

    assign o_push         = i_valid && !i_full;
    assign o_job.rejected = bad;
    assign o_job.x_wide   = i_cfg.x_wide;
    assign o_job.y_wide   = i_cfg.y_wide;
    assign o_job.xs       = xs_full[7:3];
    assign o_job.xe       = xe_full[7:3];
    assign o_job.ys       = ys_full[8:0];
    assign o_job.ye       = ye_full[8:0];

endmodule

// File: hw/rtl/epdwcg_queue.sv
`timescale 1ns / 1ps

module epdwcg_queue #(
    parameter int DEPTH = epdwcg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  epdwcg_pkg::t_job i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output epdwcg_pkg::t_job o_job
);
    import epdwcg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

endmodule

// File: hw/rtl/epdwcg_back.sv
`timescale 1ns / 1ps

module epdwcg_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  epdwcg_pkg::t_job i_job,
    output logic             o_pop,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_is_command,
    output logic [7:0]       o_byte_value,
    output logic             o_last,
    output logic             o_rejected
);
    import epdwcg_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [STEP_W-1:0] step_p1;
    logic              r_out_valid;
    t_beat             r_out;
    t_beat             n_out;
    logic              ld;
    logic              is_last;

    assign ld      = i_job_valid && (!r_out_valid || !i_stall);
    assign is_last = i_job.rejected || (r_step == SLOT_YC_HI)
                  || ((r_step == SLOT_YC_LO) && !i_job.y_wide);
    assign step_p1 = r_step + STEP_W'(1);
    assign o_pop   = ld && is_last;

    always_comb begin
        if (is_last) begin
            n_step = SLOT_XR_CMD;
        end else if (!slot_on(step_p1, i_job.x_wide, i_job.y_wide)) begin
            n_step = r_step + STEP_W'(2);
        end else begin
            n_step = step_p1;
        end
    end

    always_comb begin
        n_out.is_command = 1'b0;
        n_out.byte_value = 8'h00;
        n_out.last       = is_last;
        n_out.rejected   = i_job.rejected;
        if (!i_job.rejected) begin
            case (r_step)
                SLOT_XR_CMD: begin
                    n_out.is_command = 1'b1;
                    n_out.byte_value = CMD_XRANGE;
                end
                SLOT_YR_CMD: begin
                    n_out.is_command = 1'b1;
                    n_out.byte_value = CMD_YRANGE;
                end
                SLOT_XC_CMD: begin
                    n_out.is_command = 1'b1;
                    n_out.byte_value = CMD_XCOUNT;
                end
                SLOT_YC_CMD: begin
                    n_out.is_command = 1'b1;
                    n_out.byte_value = CMD_YCOUNT;
                end
                SLOT_XR_SLO, SLOT_XC_LO: n_out.byte_value = {3'd0, i_job.xs};
                SLOT_XR_ELO: n_out.byte_value = {3'd0, i_job.xe};
                SLOT_YR_SLO, SLOT_YC_LO: n_out.byte_value = i_job.ys[7:0];
                SLOT_YR_SHI, SLOT_YC_HI: n_out.byte_value = {7'd0, i_job.ys[8]};
                SLOT_YR_ELO: n_out.byte_value = i_job.ye[7:0];
                SLOT_YR_EHI: n_out.byte_value = {7'd0, i_job.ye[8]};
                default: n_out.byte_value = 8'h00;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= SLOT_XR_CMD;
            r_out_valid <= 1'b0;
        end else begin
            if (ld) begin
                r_step      <= n_step;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_is_command = r_out.is_command;
    assign o_byte_value = r_out.byte_value;
    assign o_last       = r_out.last;
    assign o_rejected   = r_out.rejected;

    a_reject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.rejected |-> r_out.last && !r_out.is_command
            && (r_out.byte_value == 8'h00))
        else $error("rejected transaction not a single zero data byte");

    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != SLOT_XR_CMD) |-> i_job_valid)
        else $error("window left the queue mid-sequence");

    a_first_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld && !i_job.rejected && (r_step == SLOT_XR_CMD) |=> r_out.is_command
            && (r_out.byte_value == CMD_XRANGE) && !r_out.last)
        else $error("sequence does not open with the X range command");

    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid && r_out.last && (r_step == SLOT_XR_CMD))
        else $error("window dropped without its last byte");

endmodule

// File: hw/rtl/epd_window_command_generator.sv
`timescale 1ns / 1ps

// Window command generator for an e-paper controller.
// Input channel (i_valid / o_stall): one window rectangle per transaction in
// rotated user coordinates. The front end checks it against the panel and
// maps it to RAM byte-column and gate-line ranges; the result waits in a
// small queue (QUEUE_DEPTH windows) while the back end streams it out.
// Output channel (o_valid / i_stall): one byte per transaction, with
// o_is_command, o_last on the final byte, and o_rejected on the single zero
// byte that stands for a window that failed validation.
// With the block idle, the first byte of a window is presented after the
// window is stored in the queue and then loaded into the output register.
// Throughput: the back end emits one byte per cycle while i_stall is low;
// a window is 10 to 16 bytes (1 if rejected); windows follow without gaps.
// Configuration channel (i_cfg_valid / o_cfg_ready): ready is always high;
// write registers only while no window is in flight.
// Reset: synchronous, active low; queue and serializer empty, registers take
// their defaults (296 gate lines, 128 source pixels, rotation 0, one-byte X,
// two-byte Y). When the receiver stalls, the current byte holds and the
// queue holds up to QUEUE_DEPTH windows, the one being sent included, before
// o_stall rises.

module epd_window_command_generator #(
    parameter int QUEUE_DEPTH = epdwcg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [15:0]                       i_win_x,
    input  logic [15:0]                       i_win_y,
    input  logic [15:0]                       i_win_w,
    input  logic [15:0]                       i_win_h,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_is_command,
    output logic [7:0]                        o_byte_value,
    output logic                              o_last,
    output logic                              o_rejected,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [epdwcg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [epdwcg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import epdwcg_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    t_job head_job;
    logic push;
    logic pop;
    logic full;
    logic head_valid;
    logic cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_lines   <= 9'd296;
            r_cfg.source_bytes <= 5'd16;
            r_cfg.rotation     <= ROT_0;
            r_cfg.x_wide       <= 1'b0;
            r_cfg.y_wide       <= 1'b1;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_GATE_LINES: r_cfg.gate_lines <= i_cfg_data[8:0];
                REG_SOURCE_PIX: r_cfg.source_bytes <= i_cfg_data[7:3];
                REG_ROTATION:   r_cfg.rotation <= i_cfg_data[1:0];
                REG_X_WIDE:     r_cfg.x_wide <= i_cfg_data[0];
                REG_Y_WIDE:     r_cfg.y_wide <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    epdwcg_front u_front (
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_win_x (i_win_x),
        .i_win_y (i_win_y),
        .i_win_w (i_win_w),
        .i_win_h (i_win_h),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    epdwcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    epdwcg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (head_valid),
        .i_job        (head_job),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_is_command (o_is_command),
        .o_byte_value (o_byte_value),
        .o_last       (o_last),
        .o_rejected   (o_rejected)
    );

    assign o_stall = full;

endmodule

// File: tb/epd_window_command_generator_test.sv
`timescale 1ns / 1ps

module epd_window_command_generator_test;
    import epdwcg_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [15:0]           i_win_x = '0;
    logic [15:0]           i_win_y = '0;
    logic [15:0]           i_win_w = '0;
    logic [15:0]           i_win_h = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_is_command;
    logic [7:0]            o_byte_value;
    logic                  o_last;
    logic                  o_rejected;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor copy of the panel registers, reset values.
    logic [8:0] cur_gate_lines = 9'd296;
    logic [7:0] cur_source_pixels = 8'd128;
    logic [1:0] cur_rotation = ROT_0;
    logic       cur_x_wide = 1'b0;
    logic       cur_y_wide = 1'b1;

    t_beat expected_bytes[$];
    bit    offering = 1'b0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    int    hold_request = 0;
    int    hold_left = 0;
    int    error_count = 0;
    int    windows_sent = 0;
    int    windows_rejected = 0;
    int    bytes_checked = 0;
    int    config_count = 0;

    epd_window_command_generator dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d bytes outstanding", expected_bytes.size());
        $display("FAIL");
        $finish;
    end

    // Hold off for a counted stretch when asked, else stall at random.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic report_mismatch(input string what);
        $display("%0d ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic compare_field(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h", o_byte_value));
            end else begin
                want = expected_bytes.pop_front();
                compare_field("is_command", {7'd0, o_is_command}, {7'd0, want.is_command});
                compare_field("byte_value", o_byte_value, want.byte_value);
                compare_field("last", {7'd0, o_last}, {7'd0, want.last});
                compare_field("rejected", {7'd0, o_rejected}, {7'd0, want.rejected});
                bytes_checked++;
            end
        end
    end

    task automatic push_byte(input logic is_cmd, input logic [7:0] value, input logic ends);
        expected_bytes.push_back('{is_command: is_cmd, byte_value: value, last: ends,
                                   rejected: 1'b0});
    endtask

    task automatic queue_coord_bytes(input int value, input logic wide, input logic ends);
        push_byte(1'b0, value[7:0], ends && !wide);
        if (wide) begin
            push_byte(1'b0, value[15:8], ends);
        end
    endtask

    task automatic predict_command_bytes(input logic [15:0] x, input logic [15:0] y,
                                         input logic [15:0] w, input logic [15:0] h);
        int   xi, yi, wi, hi;
        int   gates, sources;
        int   xs, xe, ys, ye;
        logic bad;
        xi = int'(x);
        yi = int'(y);
        wi = int'(w);
        hi = int'(h);
        gates = int'(cur_gate_lines);
        sources = int'({cur_source_pixels[7:3], 3'b000});
        windows_sent++;
        if (wi == 0 || hi == 0) begin
            bad = 1'b1;
        end else if (!cur_rotation[0]) begin
            bad = (xi + wi > gates) || (yi + hi > sources) || (yi % 8 != 0) || (hi % 8 != 0);
        end else begin
            bad = (yi + hi > gates) || (xi + wi > sources) || (xi % 8 != 0) || (wi % 8 != 0);
        end
        if (bad) begin
            windows_rejected++;
            expected_bytes.push_back('{is_command: 1'b0, byte_value: 8'h00, last: 1'b1,
                                       rejected: 1'b1});
            return;
        end
        case (cur_rotation)
            ROT_0: begin
                xs = (sources - 1 - yi) / 8;
                xe = (sources - yi - hi) / 8;
                ys = xi;
                ye = xi + wi - 1;
            end
            ROT_1: begin
                xs = (sources - 1 - xi) / 8;
                xe = (sources - xi - wi) / 8;
                ys = gates - 1 - yi;
                ye = gates - yi - hi;
            end
            ROT_2: begin
                xs = yi / 8;
                xe = (yi + hi - 1) / 8;
                ys = xi + wi - 1;
                ye = xi;
            end
            default: begin
                xs = xi / 8;
                xe = (xi + wi - 1) / 8;
                ys = yi;
                ye = yi + hi - 1;
            end
        endcase
        push_byte(1'b1, CMD_XRANGE, 1'b0);
        queue_coord_bytes(xs, cur_x_wide, 1'b0);
        queue_coord_bytes(xe, cur_x_wide, 1'b0);
        push_byte(1'b1, CMD_YRANGE, 1'b0);
        queue_coord_bytes(ys, cur_y_wide, 1'b0);
        queue_coord_bytes(ye, cur_y_wide, 1'b0);
        push_byte(1'b1, CMD_XCOUNT, 1'b0);
        queue_coord_bytes(xs, cur_x_wide, 1'b0);
        push_byte(1'b1, CMD_YCOUNT, 1'b0);
        queue_coord_bytes(ys, cur_y_wide, 1'b1);
    endtask

    task automatic send_window(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] w, input logic [15:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_win_x <= x;
        i_win_y <= y;
        i_win_w <= w;
        i_win_h <= h;
        offering = 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_command_bytes(x, y, w, h);
    endtask

    task automatic wait_drained();
        if (offering) begin
            i_valid <= 1'b0;
            offering = 1'b0;
        end
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_GATE_LINES: cur_gate_lines = value;
            REG_SOURCE_PIX: cur_source_pixels = value[7:0];
            REG_ROTATION:   cur_rotation = value[1:0];
            REG_X_WIDE:     cur_x_wide = value[0];
            REG_Y_WIDE:     cur_y_wide = value[0];
            default: ;
        endcase
    endtask

    // Unused indexes get random data first; they must change nothing.
    task automatic apply_config(input logic [8:0] gates, input logic [8:0] sources,
                                input logic [8:0] turns, input logic [8:0] x_two,
                                input logic [8:0] y_two);
        wait_drained();
        for (int idx = REG_Y_WIDE + 1; idx < 2 ** CFG_IDX_W; idx++) begin
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom_range(9'h1FF)));
        end
        write_reg(REG_GATE_LINES, gates);
        write_reg(REG_SOURCE_PIX, sources);
        write_reg(REG_ROTATION, turns);
        write_reg(REG_X_WIDE, x_two);
        write_reg(REG_Y_WIDE, y_two);
        i_cfg_valid <= 1'b0;
        config_count++;
    endtask

    // Mostly legal windows for the current panel, some near misses, some noise.
    task automatic send_random_window();
        int gates, sources, kind, gx, gw, sy, sh;
        gates = int'(cur_gate_lines);
        sources = int'({cur_source_pixels[7:3], 3'b000});
        kind = $urandom_range(99);
        if (kind >= 90 || gates == 0 || sources == 0) begin
            send_window(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                        16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
            return;
        end
        gx = $urandom_range(gates - 1);
        gw = $urandom_range(gates - gx, 1);
        sy = 8 * $urandom_range(sources / 8 - 1);
        sh = 8 * $urandom_range((sources - sy) / 8, 1);
        if (kind >= 75) begin
            case ($urandom_range(5))
                0: gw = 0;
                1: sh = 0;
                2: gw = gates - gx + 1;
                3: sh = sources - sy + 8;
                4: sy = sy + $urandom_range(7, 1);
                default: sh = sh + $urandom_range(7, 1);
            endcase
        end
        if (!cur_rotation[0]) begin
            send_window(16'(gx), 16'(sy), 16'(gw), 16'(sh));
        end else begin
            send_window(16'(sy), 16'(gx), 16'(sh), 16'(gw));
        end
    endtask

    task automatic test_reset_window_checks();
        send_window(0, 0, 296, 128);
        send_window(0, 0, 1, 8);
        send_window(295, 120, 1, 8);
        send_window(0, 0, 0, 8);
        send_window(0, 0, 8, 0);
        send_window(0, 0, 297, 8);
        send_window(0, 8, 1, 128);
        send_window(0, 4, 1, 8);
        send_window(0, 0, 1, 12);
        send_window(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_window(16'hFFFF, 0, 1, 8);
        wait_drained();
    endtask

    task automatic test_rotations();
        for (int r = 0; r < 4; r++) begin
            apply_config(296, 128, 9'(r), {8'd0, r[0]}, {8'd0, r[1]});
            if (!r[0]) begin
                send_window(0, 0, 296, 128);
                send_window(17, 40, 100, 48);
            end else begin
                send_window(0, 0, 128, 296);
                send_window(40, 17, 48, 100);
            end
        end
        wait_drained();
    endtask

    task automatic test_register_extremes();
        apply_config(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF);
        send_window(0, 0, 248, 511);
        send_window(240, 510, 8, 1);
        apply_config(0, 0, 0, 0, 0);
        send_window(0, 0, 1, 8);
        send_window(0, 0, 8, 8);
        apply_config(1, 15, {7'd0, ROT_2}, 1, 0);
        send_window(0, 0, 1, 8);
        send_window(1, 0, 1, 8);
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        apply_config(296, 128, {7'd0, ROT_1}, 1, 1);
        hold_request = 300;
        repeat (10) send_random_window();
        wait_drained();
        stall_pct = 50;
        repeat (5) send_random_window();
        wait_drained();
    endtask

    task automatic test_random_windows();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 34; stall_pct = 34; end
            endcase
            apply_config(9'($urandom_range(320, 1)), 9'($urandom_range(240, 8)), 9'(phase),
                         9'($urandom_range(1)), 9'($urandom_range(1)));
            repeat (28) send_random_window();
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_window_checks();
        test_rotations();
        test_register_extremes();
        test_backpressure();
        test_random_windows();
        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("%0d windows sent (%0d rejected) under %0d register settings, all rotations,",
                 windows_sent, windows_rejected, config_count);
        $display("%0d bytes checked with idle and stall rates up to 78%% and a long hold-off",
                 bytes_checked);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
